// File: hw/rtl/value_to_false_color_map_defines.svh
// Assertion macros used by the false colour mapper RTL.
`ifndef VALUE_TO_FALSE_COLOR_MAP_DEFINES_SVH
`define VALUE_TO_FALSE_COLOR_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define VFC_ASSERT_IMPL(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("vfc: assertion failed");
`define VFC_ASSERT_NEXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("vfc: assertion failed");
`else
`define VFC_ASSERT_IMPL(lbl, ck, rn, pre, post)
`define VFC_ASSERT_NEXT(lbl, ck, rn, pre, post)
`endif
`endif

// File: hw/rtl/vfc_pkg.sv
// Shared constants, types and colour anchor table of the false colour mapper.
`default_nettype none
package vfc_pkg;

  localparam int unsigned T_BITS = 16;
  localparam logic [16:0] T_ONE    = 17'd65536;
  localparam logic [16:0] T_HALF   = 17'd32768;
  localparam logic [16:0] T_BREAK1 = 17'd21627;
  localparam logic [16:0] T_BREAK2 = 17'd43254;

  typedef enum logic [1:0] {
    MODE_SEQUENTIAL = 2'd0,
    MODE_DIVERGING  = 2'd1,
    MODE_VIRIDIS    = 2'd2,
    MODE_SEQ_ALT    = 2'd3
  } map_mode_t;

  typedef enum logic [1:0] {
    REG_RANGE_LOW  = 2'd0,
    REG_RANGE_HIGH = 2'd1,
    REG_MAP_MODE   = 2'd2
  } cfg_reg_t;

  function automatic logic [7:0] anchor_chan(input logic [1:0] seg, input logic [1:0] ch);
    logic [7:0] v;
    case ({seg, ch})
      4'b0000: v = 8'd68;
      4'b0001: v = 8'd1;
      4'b0010: v = 8'd84;
      4'b0100: v = 8'd49;
      4'b0101: v = 8'd104;
      4'b0110: v = 8'd142;
      4'b1000: v = 8'd53;
      4'b1001: v = 8'd183;
      4'b1010: v = 8'd121;
      4'b1100: v = 8'd253;
      4'b1101: v = 8'd231;
      4'b1110: v = 8'd37;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [9:0] anchor_step(input logic [1:0] seg,
                                                     input logic [1:0] ch);
    logic [1:0] nseg;
    nseg = 2'(seg + 2'd1);
    return $signed({2'b00, anchor_chan(nseg, ch)}) - $signed({2'b00, anchor_chan(seg, ch)});
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/vfc_norm.sv
// Front stages: offset against range_low, span, and clamp classification.
`default_nettype none
module vfc_norm #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] sample,
  input  logic [VALUE_BITS-1:0] range_low,
  input  logic [VALUE_BITS-1:0] range_high,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_rem,
  output logic [VALUE_BITS-1:0] out_den,
  output logic                  out_one
);

  logic [1:0] v_r;
  logic [1:0] rdy;

  logic signed [VALUE_BITS:0] diff_r, diff_nxt;
  logic signed [VALUE_BITS:0] span_r, span_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] den_r, den_nxt;
  logic one_r, one_nxt;
  logic zero;

  assign rdy[1]   = ~v_r[1] | out_ready;
  assign rdy[0]   = ~v_r[0] | rdy[1];
  assign in_ready = rdy[0];

  always_comb begin
    diff_nxt = $signed({sample[VALUE_BITS-1], sample})
             - $signed({range_low[VALUE_BITS-1], range_low});
    span_nxt = $signed({range_high[VALUE_BITS-1], range_high})
             - $signed({range_low[VALUE_BITS-1], range_low});
  end

  always_comb begin
    zero    = span_r[VALUE_BITS] || (span_r == '0) || diff_r[VALUE_BITS] || (diff_r == '0);
    one_nxt = ~zero && (diff_r >= span_r);
    if (zero || one_nxt) begin
      rem_nxt = '0;
      den_nxt = VALUE_BITS'(1);
    end else begin
      rem_nxt = diff_r[VALUE_BITS-1:0];
      den_nxt = span_r[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      diff_r <= diff_nxt;
      span_r <= span_nxt;
    end
    if (rdy[1]) begin
      rem_r <= rem_nxt;
      den_r <= den_nxt;
      one_r <= one_nxt;
    end
  end

  assign out_valid = v_r[1];
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_one   = one_r;

endmodule
`default_nettype wire

// File: hw/rtl/vfc_div_stage.sv
// One restoring division step: one quotient bit of the fraction per stage.
`default_nettype none
module vfc_div_stage #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [VALUE_BITS-1:0]     in_rem,
  input  logic [VALUE_BITS-1:0]     in_den,
  input  logic [vfc_pkg::T_BITS-1:0] in_q,
  input  logic                      in_one,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [VALUE_BITS-1:0]     out_rem,
  output logic [VALUE_BITS-1:0]     out_den,
  output logic [vfc_pkg::T_BITS-1:0] out_q,
  output logic                      out_one
);
  import vfc_pkg::*;

  logic v_r;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] den_r;
  logic [T_BITS-1:0] q_r, q_nxt;
  logic one_r;
  logic [VALUE_BITS:0] rem2;
  logic [VALUE_BITS+1:0] sub;
  logic ge;

  assign in_ready = ~v_r | out_ready;

  always_comb begin
    rem2    = {in_rem, 1'b0};
    sub     = {1'b0, rem2} - {2'b00, in_den};
    ge      = ~sub[VALUE_BITS+1];
    rem_nxt = ge ? sub[VALUE_BITS-1:0] : rem2[VALUE_BITS-1:0];
    q_nxt   = {in_q[T_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem_r <= rem_nxt;
      den_r <= in_den;
      q_r   <= q_nxt;
      one_r <= in_one;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_q     = q_r;
  assign out_one   = one_r;

endmodule
`default_nettype wire

// File: hw/rtl/vfc_color.sv
// Colour stages: segment select, channel products, truncate and saturate.
`default_nettype none
`include "value_to_false_color_map_defines.svh"
module vfc_color (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [16:0]         in_t,
  input  vfc_pkg::map_mode_t  mode,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue
);
  import vfc_pkg::*;

  typedef struct packed {
    logic       vir;
    logic       lo;
    logic [1:0] seg;
  } map_ctrl_t;

  logic [2:0] v_r;
  logic [2:0] rdy;

  map_ctrl_t ctl0_r, ctl0_nxt;
  map_ctrl_t ctl1_r;
  map_ctrl_t ctl2_r;
  logic [16:0] s_r, s_nxt;
  logic signed [27:0] prod_r [3];
  logic signed [27:0] prod_nxt [3];
  logic [7:0] base_r [3];
  logic [7:0] base_nxt [3];
  logic [7:0] chan [3];
  logic [7:0] red_r, green_r, blue_r;
  logic [7:0] red_nxt, blue_nxt;

  assign rdy[2]   = ~v_r[2] | out_ready;
  assign rdy[1]   = ~v_r[1] | rdy[2];
  assign rdy[0]   = ~v_r[0] | rdy[1];
  assign in_ready = rdy[0];

  // segment and interpolation fraction
  always_comb begin
    logic [16:0] d_half;
    logic [16:0] f_two;
    logic [16:0] base;
    logic [16:0] d_vir;
    logic [18:0] s_vir;
    d_half       = in_t - T_HALF;
    ctl0_nxt.lo  = in_t < T_HALF;
    ctl0_nxt.vir = (mode == MODE_VIRIDIS);
    f_two        = ctl0_nxt.lo ? {in_t[15:0], 1'b0} : (T_ONE - {d_half[15:0], 1'b0});
    if (in_t < T_BREAK1) begin
      ctl0_nxt.seg = 2'd0;
      base         = '0;
    end else if (in_t < T_BREAK2) begin
      ctl0_nxt.seg = 2'd1;
      base         = T_BREAK1;
    end else begin
      ctl0_nxt.seg = 2'd2;
      base         = T_BREAK2;
    end
    d_vir = in_t - base;
    s_vir = {2'b00, d_vir} * 19'd3;
    s_nxt = ctl0_nxt.vir ? s_vir[16:0] : f_two;
  end

  // channel products
  always_comb begin
    logic signed [9:0] coef;
    for (int c = 0; c < 3; c++) begin
      if (ctl0_r.vir) begin
        coef        = anchor_step(ctl0_r.seg, 2'(c));
        base_nxt[c] = anchor_chan(ctl0_r.seg, 2'(c));
      end else begin
        coef        = 10'sd255;
        base_nxt[c] = 8'd0;
      end
      prod_nxt[c] = $signed({1'b0, s_r}) * coef;
    end
  end

  // add anchor, truncate toward zero, saturate
  always_comb begin
    logic signed [27:0] total;
    for (int c = 0; c < 3; c++) begin
      total = prod_r[c] + $signed({4'b0000, base_r[c], 16'h0000});
      if (total[27]) begin
        chan[c] = 8'd0;
      end else if (|total[27:24]) begin
        chan[c] = 8'd255;
      end else begin
        chan[c] = total[23:16];
      end
    end
    red_nxt  = (ctl1_r.vir || ctl1_r.lo)  ? chan[0] : 8'd255;
    blue_nxt = (ctl1_r.vir || !ctl1_r.lo) ? chan[2] : 8'd255;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ctl0_r <= ctl0_nxt;
      s_r    <= s_nxt;
    end
    if (rdy[1]) begin
      ctl1_r <= ctl0_r;
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= prod_nxt[c];
        base_r[c] <= base_nxt[c];
      end
    end
    if (rdy[2]) begin
      ctl2_r  <= ctl1_r;
      red_r   <= red_nxt;
      green_r <= chan[1];
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = v_r[2];
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

  `VFC_ASSERT_IMPL(a_two_half_full, clk, rst_n, v_r[2] && !ctl2_r.vir, red_r == 8'd255 || blue_r == 8'd255)
  `VFC_ASSERT_IMPL(a_two_half_pair, clk, rst_n, v_r[2] && !ctl2_r.vir, red_r == green_r || green_r == blue_r)
  `VFC_ASSERT_IMPL(a_vir_seg0_blue, clk, rst_n, v_r[2] && ctl2_r.vir && ctl2_r.seg == 2'd0, blue_r >= 8'd84 && blue_r <= 8'd142)
  `VFC_ASSERT_NEXT(a_mid_hold, clk, rst_n, v_r[1] && !rdy[2], v_r[1])

endmodule
`default_nettype wire

// File: hw/rtl/value_to_false_color_map.sv
// Top level of the false colour mapper: registers, divider chain, colour stages.
//
//  channel | dir | handshake               | word
//  in_     | in  | in_tvalid / in_tready   | tdata: sample_value
//  out_    | out | out_tvalid / out_tready | tdata: {blue, green, red}
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One word per clock in and out while out_tready stays high; the pipeline has two
// normalising stages, sixteen divider stages (one quotient bit each) and three colour stages.
// Reset clears every stage valid bit and the three registers to zero.
// Each stage holds its word only while the next is full and stalled, so bubbles
// are squeezed out and input is taken while a result waits at the output.
// cfg_ready is always high; write registers only while the pipeline is empty.
`default_nettype none
module value_to_false_color_map #(
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_BITS-1:0] in_tdata,   // sample_value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // {blue, green, red}
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_data
);
  import vfc_pkg::*;

  logic [VALUE_BITS-1:0] range_low_r;
  logic [VALUE_BITS-1:0] range_high_r;
  map_mode_t             map_mode_r;

  logic [VALUE_BITS-1:0] rem_c [T_BITS+1];
  logic [VALUE_BITS-1:0] den_c [T_BITS+1];
  logic [T_BITS-1:0]     q_c   [T_BITS+1];
  logic [T_BITS:0]       one_c;
  logic [T_BITS:0]       v_c;
  logic [T_BITS:0]       r_c;

  logic [16:0] t_frac;
  logic [7:0]  red, green, blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= '0;
      map_mode_r   <= MODE_SEQUENTIAL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  range_low_r  <= cfg_data;
        REG_RANGE_HIGH: range_high_r <= cfg_data;
        REG_MAP_MODE:   map_mode_r   <= map_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  vfc_norm #(.VALUE_BITS(VALUE_BITS)) u_norm (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .sample     (in_tdata[VALUE_BITS-1:0]),
    .range_low  (range_low_r),
    .range_high (range_high_r),
    .out_valid  (v_c[0]),
    .out_ready  (r_c[0]),
    .out_rem    (rem_c[0]),
    .out_den    (den_c[0]),
    .out_one    (one_c[0])
  );

  assign q_c[0] = '0;

  for (genvar i = 0; i < T_BITS; i++) begin : g_div
    vfc_div_stage #(.VALUE_BITS(VALUE_BITS)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_c[i]),
      .in_ready  (r_c[i]),
      .in_rem    (rem_c[i]),
      .in_den    (den_c[i]),
      .in_q      (q_c[i]),
      .in_one    (one_c[i]),
      .out_valid (v_c[i+1]),
      .out_ready (r_c[i+1]),
      .out_rem   (rem_c[i+1]),
      .out_den   (den_c[i+1]),
      .out_q     (q_c[i+1]),
      .out_one   (one_c[i+1])
    );
  end

  assign t_frac = one_c[T_BITS] ? T_ONE : {1'b0, q_c[T_BITS]};

  vfc_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_c[T_BITS]),
    .in_ready  (r_c[T_BITS]),
    .in_t      (t_frac),
    .mode      (map_mode_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign out_tdata = {blue, green, red};

endmodule
`default_nettype wire
